// ----- rtl/core/tdc_pkg.sv -----
`default_nettype none
package tdc_pkg;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_MANUAL_SPEED = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_PULSE_POWER  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN    = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED    = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_DEAD_BAND    = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_PULSE_ZONE   = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_ON_TICKS     = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_OFF_TICKS    = 4'd7;

  localparam logic [6:0] RST_MANUAL_SPEED = 7'd47;
  localparam logic [6:0] RST_PULSE_POWER  = 7'd22;
  localparam logic [6:0] RST_PROP_GAIN    = 7'd18;
  localparam logic [6:0] RST_MAX_SPEED    = 7'd127;
  localparam logic [7:0] RST_DEAD_BAND    = 8'd2;
  localparam logic [7:0] RST_PULSE_ZONE   = 8'd14;
  localparam logic [7:0] RST_ON_TICKS     = 8'd2;
  localparam logic [7:0] RST_OFF_TICKS    = 8'd10;

  localparam logic [7:0] PWM_NEUTRAL = 8'd127;
  localparam logic [7:0] LED_FAST_MAX = 8'd12;
  localparam logic [7:0] LED_ON_MAX   = 8'd1;

  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  typedef struct packed {
    logic [7:0] off_ticks;
    logic [7:0] on_ticks;
    logic [7:0] pulse_zone;
    logic [7:0] dead_band;
    logic [6:0] max_speed;
    logic [6:0] prop_gain;
    logic [6:0] pulse_power;
    logic [6:0] manual_speed;
  } cfg_t;

  typedef struct packed {
    logic              left_button;
    logic              right_button;
    logic              cw_limit;
    logic              ccw_limit;
    logic              target_seen;
    logic signed [7:0] tracking_error;
  } item_t;

  typedef struct packed {
    logic [7:0] motor_pwm;
    logic       pwm_written;
    logic       status_led;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/tdc_regs.sv -----
`default_nettype none
module tdc_regs
  import tdc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.manual_speed <= RST_MANUAL_SPEED;
      cfg.pulse_power  <= RST_PULSE_POWER;
      cfg.prop_gain    <= RST_PROP_GAIN;
      cfg.max_speed    <= RST_MAX_SPEED;
      cfg.dead_band    <= RST_DEAD_BAND;
      cfg.pulse_zone   <= RST_PULSE_ZONE;
      cfg.on_ticks     <= RST_ON_TICKS;
      cfg.off_ticks    <= RST_OFF_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MANUAL_SPEED: cfg.manual_speed <= cfg_data[6:0];
        REG_PULSE_POWER:  cfg.pulse_power  <= cfg_data[6:0];
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[6:0];
        REG_MAX_SPEED:    cfg.max_speed    <= cfg_data[6:0];
        REG_DEAD_BAND:    cfg.dead_band    <= cfg_data;
        REG_PULSE_ZONE:   cfg.pulse_zone   <= cfg_data;
        REG_ON_TICKS:     cfg.on_ticks     <= cfg_data;
        REG_OFF_TICKS:    cfg.off_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tdc_core.sv -----
`default_nettype none
module tdc_core
  import tdc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire logic  step,
  output result_t    res
);

  logic [7:0] pwm_hold, pwm_hold_next;
  logic [7:0] pulse_timer, pulse_timer_next;
  logic       pulse_phase_on, pulse_phase_on_next;
  logic [7:0] blink_count, blink_count_next;
  logic       led_hold, led_hold_next;

  logic        manual;
  logic [7:0]  err_eff;
  logic        neg;
  logic [7:0]  mag;
  logic [14:0] prod;
  logic [15:0] prod_up;
  logic [10:0] raw_sp;
  logic [6:0]  prop_sp;
  logic [6:0]  dmag;
  logic        dneg;
  logic        blocked;
  logic [7:0]  drive_pwm;
  logic [7:0]  pulse_pwm;
  logic        above_dead;
  logic        in_pulse;
  logic        in_prop;
  logic        written;

  always_comb begin
    manual  = item.left_button ^ item.right_button;
    err_eff = item.target_seen ? item.tracking_error : 8'sd0;
    neg     = err_eff[7];
    // -128 comes out as 128 in the unsigned magnitude
    mag     = neg ? (~err_eff + 8'd1) : err_eff;

    prod    = {7'd0, mag} * {8'd0, cfg.prop_gain};
    // negative side rounds away from zero
    prod_up = {1'b0, prod} + 16'd31;
    raw_sp  = neg ? prod_up[15:5] : {1'b0, prod[14:5]};
    prop_sp = (raw_sp > {4'd0, cfg.max_speed}) ? cfg.max_speed : raw_sp[6:0];

    dmag = manual ? cfg.manual_speed : prop_sp;
    dneg = manual ? item.right_button : neg;
    blocked = (dmag != 7'd0) && ((!dneg && item.cw_limit) || (dneg && item.ccw_limit));
    drive_pwm = dneg ? (PWM_NEUTRAL - {1'b0, dmag}) : (PWM_NEUTRAL + {1'b0, dmag});
    pulse_pwm = neg ? (PWM_NEUTRAL - {1'b0, cfg.pulse_power})
                    : (PWM_NEUTRAL + {1'b0, cfg.pulse_power});

    above_dead = mag >= cfg.dead_band;
    in_pulse   = !manual && above_dead && (mag < cfg.pulse_zone) && (mag != 8'd0);
    in_prop    = !manual && above_dead && (mag >= cfg.pulse_zone);

    pulse_timer_next    = pulse_timer;
    pulse_phase_on_next = pulse_phase_on;
    if (in_pulse) begin
      if (pulse_timer == 8'd0) begin
        pulse_phase_on_next = !pulse_phase_on;
        pulse_timer_next    = pulse_phase_on ? cfg.off_ticks : cfg.on_ticks;
      end else begin
        pulse_timer_next = pulse_timer - 8'd1;
      end
    end

    if (manual || in_prop) begin
      written = !blocked;
    end else if (in_pulse) begin
      written = pulse_phase_on_next;
    end else begin
      written = 1'b0;
    end

    if (!written) begin
      pwm_hold_next = pwm_hold;
    end else if (in_pulse) begin
      pwm_hold_next = pulse_pwm;
    end else begin
      pwm_hold_next = drive_pwm;
    end

    blink_count_next = manual ? blink_count : blink_count + 8'd1;
    if (manual) begin
      led_hold_next = led_hold;
    end else if (!item.target_seen) begin
      led_hold_next = 1'b0;
    end else if (mag <= LED_ON_MAX) begin
      led_hold_next = 1'b1;
    end else if (mag <= LED_FAST_MAX) begin
      led_hold_next = blink_count_next[2];
    end else begin
      led_hold_next = blink_count_next[4];
    end

    res.motor_pwm   = pwm_hold_next;
    res.pwm_written = written;
    res.status_led  = led_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_hold       <= PWM_NEUTRAL;
      pulse_timer    <= 8'd0;
      pulse_phase_on <= 1'b0;
      blink_count    <= 8'd0;
      led_hold       <= 1'b0;
    end else if (step) begin
      pwm_hold       <= pwm_hold_next;
      pulse_timer    <= pulse_timer_next;
      pulse_phase_on <= pulse_phase_on_next;
      blink_count    <= blink_count_next;
      led_hold       <= led_hold_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/turret_drive_controller.sv -----
// turret drive controller
// input stream s_*: one control tick per beat; tdata holds the buttons, limit
// switches, target flag and signed tracking error. output stream m_*: one
// result beat per input beat, in order, carrying the motor pwm byte, the
// written flag and the status led.
// config: cfg_we/cfg_index/cfg_data write one register per cycle, indexes past
// the last register are dropped; write only while no tick is in flight.
// pipeline: an input register, then the control logic and the per-tick state
// (pwm hold, pulse timer and phase, blink counter, led) feeding a result
// register. throughput is one beat per cycle while the output is not stalled;
// each stage advances when the stage after it is empty or being drained, so
// a new beat is taken while a finished result waits. when m_tready stays
// low both stages fill and s_tready drops.
// reset (rst, synchronous) empties both stages, restores register defaults
// and sets the pwm hold to neutral 127.
`default_nettype none
module turret_drive_controller
  import tdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // left_button, right_button, cw_limit, ccw_limit, target_seen,
  // tracking_error[7:0], zero pad
  input  wire logic [InDataW-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // motor_pwm[7:0], pwm_written, status_led, zero pad
  output logic [OutDataW-1:0]       m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t res;
  result_t out_res;
  logic    adv_in;
  logic    adv_out;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv_in   = in_valid && adv_out;
  assign s_tready = !in_valid || adv_out;

  tdc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .step (adv_in),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.left_button    <= s_tdata[0];
      in_item.right_button   <= s_tdata[1];
      in_item.cw_limit       <= s_tdata[2];
      in_item.ccw_limit      <= s_tdata[3];
      in_item.target_seen    <= s_tdata[4];
      in_item.tracking_error <= s_tdata[12:5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.status_led, out_res.pwm_written, out_res.motor_pwm};

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a stalled output");

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv_in) |=> in_valid)
    else $error("input stage dropped a tick");

  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] != 8'd255))
    else $error("pwm byte out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv_in |=> m_tvalid)
    else $error("advanced tick did not reach the output");

endmodule
`default_nettype wire
